[src/hscd_pkg.sv]
// Shared types, constants and jamo mapping tables for the Hangul syllable block.
`timescale 1ns / 1ps
package hscd_pkg;

  // Precomposed syllable block and its split into initial / medial / final.
  localparam logic [31:0] SYL_BASE = 32'h0000_AC00;
  localparam logic [31:0] SYL_LAST = 32'h0000_D7AF;
  localparam int INI_SPAN = 588;
  localparam int MED_SPAN = 28;
  localparam int NUM_INI = 19;
  localparam int NUM_MED = 21;

  // Compatibility jamo block.
  localparam logic [31:0] JAMO_BASE = 32'h0000_3131;
  localparam logic [31:0] JAMO_LAST = 32'h0000_3163;

  // Positional (conjoining) jamo ranges.
  localparam logic [31:0] POS_INI_FIRST = 32'h0000_1100;
  localparam logic [31:0] POS_INI_LAST = 32'h0000_1112;
  localparam logic [31:0] POS_MED_FIRST = 32'h0000_1161;
  localparam logic [31:0] POS_MED_LAST = 32'h0000_1175;
  localparam logic [31:0] POS_FIN_FIRST = 32'h0000_11A8;
  localparam logic [31:0] POS_FIN_LAST = 32'h0000_11C2;

  // Marker for an encapsulated non-Hangul character.
  localparam logic [31:0] NON_HANGUL = 32'hFFFF_FFFE;

  // Compatibility index that stands for "no final consonant".
  localparam logic [5:0] FIN_NONE = 6'd51;

  typedef enum logic [0:0] {
    KIND_ANALYZE = 1'b0,
    KIND_COMPOSE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_INITIAL = 3'd1,
    STATUS_BAD_MEDIAL  = 3'd2,
    STATUS_BAD_FINAL   = 3'd3,
    STATUS_RANGE       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLASS_OTHER    = 2'd0,
    CLASS_SYLLABLE = 2'd1,
    CLASS_JAMO     = 2'd2,
    CLASS_ENCAP    = 2'd3
  } class_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] codepoint_in;
    logic [5:0]  initial_in;
    logic [5:0]  medial_in;
    logic [5:0]  final_in;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    class_t      char_class;
    logic [31:0] codepoint_out;
    logic [13:0] syllable_offset;
    logic [5:0]  initial_out;
    logic [5:0]  medial_out;
    logic [5:0]  final_out;
    logic [5:0]  jamo_index;
  } out_item_t;

  // Result of a compatibility-to-positional lookup: hit is low for a miss.
  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } jamo_map_t;

  function automatic jamo_map_t comp_to_ini(input logic [5:0] c);
    jamo_map_t r;
    r.hit = 1'b1;
    case (c)
      6'd0:    r.idx = 5'd0;
      6'd1:    r.idx = 5'd1;
      6'd3:    r.idx = 5'd2;
      6'd6:    r.idx = 5'd3;
      6'd7:    r.idx = 5'd4;
      6'd8:    r.idx = 5'd5;
      6'd16:   r.idx = 5'd6;
      6'd17:   r.idx = 5'd7;
      6'd18:   r.idx = 5'd8;
      6'd20:   r.idx = 5'd9;
      6'd21:   r.idx = 5'd10;
      6'd22:   r.idx = 5'd11;
      6'd23:   r.idx = 5'd12;
      6'd24:   r.idx = 5'd13;
      6'd25:   r.idx = 5'd14;
      6'd26:   r.idx = 5'd15;
      6'd27:   r.idx = 5'd16;
      6'd28:   r.idx = 5'd17;
      6'd29:   r.idx = 5'd18;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Vowels occupy compatibility indices 30 through 50 in order.
  function automatic jamo_map_t comp_to_med(input logic [5:0] c);
    jamo_map_t r;
    r.hit = (c >= 6'd30) && (c <= 6'd50);
    r.idx = r.hit ? 5'(c - 6'd30) : 5'd0;
    return r;
  endfunction

  // Finals skip the compatibility letters that only occur as initials.
  function automatic jamo_map_t comp_to_fin(input logic [5:0] c);
    jamo_map_t r;
    r.hit = 1'b1;
    if (c <= 6'd6) begin
      r.idx = 5'(c + 6'd1);
    end else if (c >= 6'd8 && c <= 6'd17) begin
      r.idx = 5'(c);
    end else if (c >= 6'd19 && c <= 6'd23) begin
      r.idx = 5'(c - 6'd1);
    end else if (c >= 6'd25 && c <= 6'd29) begin
      r.idx = 5'(c - 6'd2);
    end else if (c == FIN_NONE) begin
      r.idx = 5'd0;
    end else begin
      r.hit = 1'b0;
      r.idx = 5'd0;
    end
    return r;
  endfunction

  function automatic logic [5:0] ini_to_comp(input logic [4:0] i);
    logic [5:0] r;
    case (i)
      5'd0:    r = 6'd0;
      5'd1:    r = 6'd1;
      5'd2:    r = 6'd3;
      5'd3:    r = 6'd6;
      5'd4:    r = 6'd7;
      5'd5:    r = 6'd8;
      5'd6:    r = 6'd16;
      5'd7:    r = 6'd17;
      5'd8:    r = 6'd18;
      5'd9:    r = 6'd20;
      5'd10:   r = 6'd21;
      5'd11:   r = 6'd22;
      5'd12:   r = 6'd23;
      5'd13:   r = 6'd24;
      5'd14:   r = 6'd25;
      5'd15:   r = 6'd26;
      5'd16:   r = 6'd27;
      5'd17:   r = 6'd28;
      5'd18:   r = 6'd29;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] med_to_comp(input logic [4:0] m);
    return 6'(m) + 6'd30;
  endfunction

  function automatic logic [5:0] fin_to_comp(input logic [4:0] f);
    logic [5:0] r;
    case (f)
      5'd0:    r = FIN_NONE;
      5'd1:    r = 6'd0;
      5'd2:    r = 6'd1;
      5'd3:    r = 6'd2;
      5'd4:    r = 6'd3;
      5'd5:    r = 6'd4;
      5'd6:    r = 6'd5;
      5'd7:    r = 6'd6;
      5'd8:    r = 6'd8;
      5'd9:    r = 6'd9;
      5'd10:   r = 6'd10;
      5'd11:   r = 6'd11;
      5'd12:   r = 6'd12;
      5'd13:   r = 6'd13;
      5'd14:   r = 6'd14;
      5'd15:   r = 6'd15;
      5'd16:   r = 6'd16;
      5'd17:   r = 6'd17;
      5'd18:   r = 6'd19;
      5'd19:   r = 6'd20;
      5'd20:   r = 6'd21;
      5'd21:   r = 6'd22;
      5'd22:   r = 6'd23;
      5'd23:   r = 6'd25;
      5'd24:   r = 6'd26;
      5'd25:   r = 6'd27;
      5'd26:   r = 6'd28;
      5'd27:   r = 6'd29;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[src/hscd_compose.sv]
// Syllable composition from three compatibility jamo indices.
`timescale 1ns / 1ps
module hscd_compose (
  input  logic [5:0]          initial_in,
  input  logic [5:0]          medial_in,
  input  logic [5:0]          final_in,
  output hscd_pkg::out_item_t res
);
  import hscd_pkg::*;

  jamo_map_t   ini;
  jamo_map_t   med;
  jamo_map_t   fin;
  logic [13:0] offset;

  assign ini = comp_to_ini(initial_in);
  assign med = comp_to_med(medial_in);
  assign fin = comp_to_fin(final_in);

  assign offset = 14'(14'(ini.idx) * 14'(INI_SPAN)) + 14'(14'(med.idx) * 14'(MED_SPAN))
                + 14'(fin.idx);

  // A valid triple always lands inside the table range, and the inverse
  // tables return the input indices, so the analysis is known up front.
  always_comb begin
    res = '0;
    if (!ini.hit) begin
      res.status = STATUS_BAD_INITIAL;
    end else if (!med.hit) begin
      res.status = STATUS_BAD_MEDIAL;
    end else if (!fin.hit) begin
      res.status = STATUS_BAD_FINAL;
    end else begin
      res.status          = STATUS_OK;
      res.char_class      = CLASS_SYLLABLE;
      res.codepoint_out   = SYL_BASE + 32'(offset);
      res.syllable_offset = offset;
      res.initial_out     = initial_in;
      res.medial_out      = medial_in;
      res.final_out       = final_in;
    end
  end

endmodule

[src/hscd_analyze.sv]
// Codepoint normalization, classification and syllable decomposition.
`timescale 1ns / 1ps
module hscd_analyze (
  input  logic [31:0]         codepoint_in,
  output hscd_pkg::out_item_t res
);
  import hscd_pkg::*;

  logic [31:0]        cp;
  logic               pos_ini;
  logic               pos_med;
  logic               pos_fin;
  logic [5:0]         pos_idx;
  logic               is_syl;
  logic               is_jamo;
  logic [13:0]        off;
  logic [NUM_INI-1:0] ini_thermo;
  logic [4:0]         ini_q;
  logic [9:0]         ini_rem;
  logic [NUM_MED-2:0] med_thermo;
  logic [4:0]         med_q;
  logic [4:0]         fin_q;

  assign cp = codepoint_in;

  // Positional jamo fold onto compatibility jamo.
  assign pos_ini = (cp >= POS_INI_FIRST) && (cp <= POS_INI_LAST);
  assign pos_med = (cp >= POS_MED_FIRST) && (cp <= POS_MED_LAST);
  assign pos_fin = (cp >= POS_FIN_FIRST) && (cp <= POS_FIN_LAST);

  always_comb begin
    if (pos_ini) begin
      pos_idx = ini_to_comp(5'(cp - POS_INI_FIRST));
    end else if (pos_med) begin
      pos_idx = med_to_comp(5'(cp - POS_MED_FIRST));
    end else begin
      pos_idx = fin_to_comp(5'(cp - POS_FIN_FIRST + 32'd1));
    end
  end

  assign is_syl  = (cp >= SYL_BASE) && (cp <= SYL_LAST);
  assign is_jamo = (cp >= JAMO_BASE) && (cp <= JAMO_LAST);
  assign off     = 14'(cp - SYL_BASE);

  // Division by 588 and 28 as parallel threshold compares; the count of
  // thresholds passed is the quotient.
  always_comb begin
    for (int k = 1; k <= NUM_INI; k++) begin
      ini_thermo[k-1] = off >= 14'(k * INI_SPAN);
    end
  end

  assign ini_q   = 5'($countones(ini_thermo));
  assign ini_rem = 10'(off - 14'(14'(ini_q) * 14'(INI_SPAN)));

  always_comb begin
    for (int k = 1; k < NUM_MED; k++) begin
      med_thermo[k-1] = ini_rem >= 10'(k * MED_SPAN);
    end
  end

  assign med_q = 5'($countones(med_thermo));
  assign fin_q = 5'(ini_rem - 10'(10'(med_q) * 10'(MED_SPAN)));

  always_comb begin
    res = '0;
    if (pos_ini || pos_med || pos_fin) begin
      res.char_class    = CLASS_JAMO;
      res.codepoint_out = JAMO_BASE + 32'(pos_idx);
      res.jamo_index    = pos_idx;
    end else begin
      res.codepoint_out = cp;
      if (is_syl) begin
        res.char_class      = CLASS_SYLLABLE;
        res.syllable_offset = off;
        if (ini_q < 5'(NUM_INI)) begin
          res.initial_out = ini_to_comp(ini_q);
          res.medial_out  = med_to_comp(med_q);
          res.final_out   = fin_to_comp(fin_q);
        end else begin
          res.status = STATUS_RANGE;
        end
      end else if (is_jamo) begin
        res.char_class = CLASS_JAMO;
        res.jamo_index = 6'(cp - JAMO_BASE);
      end else if (cp == NON_HANGUL) begin
        res.char_class = CLASS_ENCAP;
      end
    end
  end

endmodule

[src/hangul_syllable_compose_decompose.sv]
// Top level of the Hangul syllable analyzer and composer.
`timescale 1ns / 1ps
// An item accepted at a clock edge is captured in the input register (in_reg, in_valid), then
// in the result register (result, done), where its result shows with done high.
// Throughput: one item per cycle; busy stays low and start may be held high every cycle.
// The rate is set by the single combinational pass between the input and result registers.
// Reset (rst, synchronous, active high) clears both valid flags, so no stray result
// appears; the payload registers are not reset. The receiver cannot stall the block.
module hangul_syllable_compose_decompose (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hscd_pkg::in_item_t  in_item,
  output logic                done,
  output hscd_pkg::out_item_t result
);
  import hscd_pkg::*;

  // Input stage: the accepted item and a flag that marks it as live.
  logic      in_valid;
  in_item_t  in_reg;

  // Both paths are evaluated on every item; kind picks one of them.
  out_item_t compose_res;
  out_item_t analyze_res;
  out_item_t result_next;

  // The pipeline never backs up: the receiver must take every result in the cycle it
  // appears (the block itself does not enforce this), so the block is always free for a new item.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_reg <= in_item;
    end
  end

  hscd_compose u_compose (
    .initial_in (in_reg.initial_in),
    .medial_in  (in_reg.medial_in),
    .final_in   (in_reg.final_in),
    .res        (compose_res)
  );

  hscd_analyze u_analyze (
    .codepoint_in (in_reg.codepoint_in),
    .res          (analyze_res)
  );

  assign result_next = (in_reg.kind == KIND_COMPOSE) ? compose_res : analyze_res;

  // Result stage: done is a one-cycle strobe that follows each live item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

  // Every accepted item is followed by a result, with done high, once it has passed the input and result registers.
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  // A rejected compose request carries nothing but its status.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_BAD_INITIAL || result.status == STATUS_BAD_MEDIAL ||
              result.status == STATUS_BAD_FINAL))
    |-> (result.char_class == CLASS_OTHER && result.codepoint_out == 32'd0))
    else $error("rejected compose request has a nonzero payload");

  // A syllable's offset always agrees with its codepoint.
  a_syl_offset: assert property (@(posedge clk) disable iff (rst)
    (done && result.char_class == CLASS_SYLLABLE)
    |-> (result.syllable_offset == 14'(result.codepoint_out - SYL_BASE)))
    else $error("syllable offset does not match codepoint");

  // The jamo index is only meaningful for the jamo class.
  a_jamo_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.char_class != CLASS_JAMO) |-> (result.jamo_index == 6'd0))
    else $error("jamo index set outside the jamo class");

endmodule
